// ----- hdl/jdef_pkg.sv -----
`timescale 1ns / 1ps

package jdef_pkg;

  localparam int unsigned MaxFrameBytesDefault = 65536;
  localparam int unsigned MaxNestingDefault = 255;
  localparam int unsigned FrameLengthWidth = 17;

  localparam logic [7:0] ChObjOpen = 8'h7B;
  localparam logic [7:0] ChObjClose = 8'h7D;
  localparam logic [7:0] ChArrOpen = 8'h5B;
  localparam logic [7:0] ChArrClose = 8'h5D;
  localparam logic [7:0] ChBackslash = 8'h5C;
  localparam logic [7:0] ChQuote = 8'h22;

  typedef enum logic [1:0] {
    STATUS_DONE = 2'd0,
    STATUS_NEST_OVERFLOW = 2'd1,
    STATUS_LENGTH_OVERFLOW = 2'd2
  } status_t;

  typedef struct packed {
    logic active;
    logic kind;
    logic quoted;
    logic skip;
  } doc_flags_t;

  typedef struct packed {
    logic emit;
    status_t status;
    logic kind;
  } step_result_t;

endpackage

// ----- hdl/jdef_step.sv -----
`timescale 1ns / 1ps

module jdef_step #(
  parameter int unsigned MAX_FRAME_BYTES = jdef_pkg::MaxFrameBytesDefault,
  parameter int unsigned MAX_NESTING = jdef_pkg::MaxNestingDefault,
  parameter int unsigned CW = $clog2(MAX_FRAME_BYTES + 1),
  parameter int unsigned NW = $clog2(MAX_NESTING + 1)
) (
  input  logic [7:0]             data_byte,
  input  logic                   flush,
  input  jdef_pkg::doc_flags_t   flags,
  input  logic [CW-1:0]          count,
  input  logic [NW-1:0]          nest,
  output jdef_pkg::doc_flags_t   flags_next,
  output logic [CW-1:0]          count_next,
  output logic [NW-1:0]          nest_next,
  output logic [CW-1:0]          length,
  output jdef_pkg::step_result_t result
);

  jdef_pkg::doc_flags_t f;
  logic [CW-1:0] cnt1;
  logic [NW-1:0] lvl;
  logic [7:0] opener;
  logic [7:0] closer;

  always_comb begin
    f = flush ? '0 : flags;
    lvl = flush ? '0 : nest;
    cnt1 = (flush ? '0 : count) + CW'(1);
    opener = f.kind ? jdef_pkg::ChArrOpen : jdef_pkg::ChObjOpen;
    closer = f.kind ? jdef_pkg::ChArrClose : jdef_pkg::ChObjClose;
    result.emit = 1'b0;
    result.status = jdef_pkg::STATUS_DONE;
    if (!f.active) begin
      if (data_byte == jdef_pkg::ChObjOpen || data_byte == jdef_pkg::ChArrOpen) begin
        f.active = 1'b1;
        f.kind = (data_byte == jdef_pkg::ChArrOpen);
        f.quoted = 1'b0;
        f.skip = 1'b0;
        lvl = NW'(1);
      end
    end else if (f.skip) begin
      f.skip = 1'b0;
    end else if (data_byte == jdef_pkg::ChBackslash) begin
      f.skip = 1'b1;
    end else if (data_byte == jdef_pkg::ChQuote) begin
      f.quoted = !f.quoted;
    end else if (!f.quoted) begin
      if (data_byte == opener) begin
        if (lvl >= NW'(MAX_NESTING)) begin
          result.emit = 1'b1;
          result.status = jdef_pkg::STATUS_NEST_OVERFLOW;
        end else begin
          lvl = lvl + NW'(1);
        end
      end else if (data_byte == closer) begin
        lvl = lvl - NW'(1);
        if (lvl == '0) begin
          result.emit = 1'b1;
          result.status = jdef_pkg::STATUS_DONE;
        end
      end
    end
    if (!result.emit && cnt1 >= CW'(MAX_FRAME_BYTES)) begin
      result.emit = 1'b1;
      result.status = jdef_pkg::STATUS_LENGTH_OVERFLOW;
    end
    result.kind = f.kind;
    length = cnt1;
    if (result.emit) begin
      flags_next = '0;
      count_next = '0;
      nest_next = '0;
    end else begin
      flags_next = f;
      count_next = cnt1;
      nest_next = lvl;
    end
  end

endmodule

// ----- hdl/json_document_end_framer_top.sv -----
`timescale 1ns / 1ps
// A result appears on the output in the cycle after the word that completes it is taken.
// Throughput: one byte per cycle while in_ready is high; the scan state is updated in a single pass per byte.
// A result that is not yet taken holds off the input; a new byte is taken in the cycle it leaves.
// Reset (synchronous, active high) returns the scanner to searching and empties the output.
// No clearing pass is needed.

module json_document_end_framer_top #(
  parameter int unsigned MAX_FRAME_BYTES = jdef_pkg::MaxFrameBytesDefault,
  parameter int unsigned MAX_NESTING = jdef_pkg::MaxNestingDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        flush,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [16:0] frame_length,
  output logic        is_array,
  output logic [1:0]  status
);

  localparam int unsigned CW = $clog2(MAX_FRAME_BYTES + 1);
  localparam int unsigned NW = $clog2(MAX_NESTING + 1);
  localparam int unsigned LW = jdef_pkg::FrameLengthWidth;

  jdef_pkg::doc_flags_t flags;
  jdef_pkg::doc_flags_t flags_next;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic [NW-1:0] nest;
  logic [NW-1:0] nest_next;
  logic [CW-1:0] length;
  logic [CW+LW-1:0] length_ext;
  jdef_pkg::step_result_t result;
  logic accept;

  jdef_step #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES),
    .MAX_NESTING(MAX_NESTING),
    .CW(CW),
    .NW(NW)
  ) u_step (
    .data_byte(data_byte),
    .flush(flush),
    .flags(flags),
    .count(count),
    .nest(nest),
    .flags_next(flags_next),
    .count_next(count_next),
    .nest_next(nest_next),
    .length(length),
    .result(result)
  );

  assign in_ready = !out_valid || out_ready;
  assign accept = in_valid && in_ready;
  assign length_ext = {{LW{1'b0}}, length};

  always_ff @(posedge clk) begin
    if (rst) begin
      flags <= '0;
      count <= '0;
      nest <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        flags <= flags_next;
        count <= count_next;
        nest <= nest_next;
      end
      if (accept && result.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && result.emit) begin
      frame_length <= length_ext[LW-1:0];
      is_array <= result.kind;
      status <= result.status;
    end
  end

  // The count always restarts on reaching the limit, so it stays below it.
  a_count_below_limit: assert property (@(posedge clk) disable iff (rst)
    count < CW'(MAX_FRAME_BYTES))
    else $error("byte count reached the frame limit without restarting");

  a_nest_in_range: assert property (@(posedge clk) disable iff (rst)
    nest <= NW'(MAX_NESTING))
    else $error("nesting level above its maximum");

  a_search_clean: assert property (@(posedge clk) disable iff (rst)
    !flags.active |-> (nest == '0 && !flags.quoted && !flags.skip && !flags.kind))
    else $error("searching with document state left over");

  a_inside_nested: assert property (@(posedge clk) disable iff (rst)
    flags.active |-> nest != '0)
    else $error("inside a document at nesting level zero");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(frame_length) && $stable(status))
    else $error("stalled result was lost or changed");

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned FrameLimit = jdef_pkg::MaxFrameBytesDefault;
  localparam int unsigned NestLimit = jdef_pkg::MaxNestingDefault;
  localparam int unsigned RandomItems = 1570;
  localparam int unsigned StallLimit = 2000;
  localparam int unsigned TailCycles = 4;
  localparam logic [7:0] ChLetterA = 8'h61;

  typedef struct packed {
    logic [16:0]       len;
    logic              kind;
    jdef_pkg::status_t code;
  } frame_t;

  typedef struct {
    logic [7:0]  value;
    logic        fl;
    int unsigned reps;
    bit          fixed;
    frame_t      want;
  } row_t;

  localparam frame_t NoFrame = '0;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = 8'h00;
  logic        flush = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [16:0] frame_length;
  logic        is_array;
  logic [1:0]  status;

  frame_t      frames_due[$];
  logic [7:0]  burst_bytes[$];
  logic        burst_flush[$];
  int unsigned mismatches = 0;
  int unsigned stall_cycles = 0;
  bit          calm = 1'b0;

  bit          in_doc;
  bit          doc_is_array;
  int unsigned depth;
  bit          in_string;
  bit          escaped;
  int unsigned seen_bytes;

  row_t plan [20] = '{
    '{jdef_pkg::ChObjOpen,   1'b0, 1,   1'b0, NoFrame},
    '{jdef_pkg::ChObjClose,  1'b0, 1,   1'b1, '{17'd2, 1'b0, jdef_pkg::STATUS_DONE}},
    '{ChLetterA,             1'b0, 3,   1'b0, NoFrame},
    '{jdef_pkg::ChArrOpen,   1'b0, 1,   1'b0, NoFrame},
    '{jdef_pkg::ChArrClose,  1'b0, 1,   1'b1, '{17'd5, 1'b1, jdef_pkg::STATUS_DONE}},
    '{jdef_pkg::ChBackslash, 1'b0, 1,   1'b0, NoFrame},
    '{jdef_pkg::ChObjOpen,   1'b0, 1,   1'b0, NoFrame},
    '{jdef_pkg::ChQuote,     1'b0, 1,   1'b0, NoFrame},
    '{jdef_pkg::ChObjClose,  1'b0, 1,   1'b0, NoFrame},
    '{jdef_pkg::ChQuote,     1'b0, 1,   1'b0, NoFrame},
    '{jdef_pkg::ChBackslash, 1'b0, 1,   1'b0, NoFrame},
    '{jdef_pkg::ChObjClose,  1'b0, 1,   1'b0, NoFrame},
    '{jdef_pkg::ChArrOpen,   1'b0, 1,   1'b0, NoFrame},
    '{jdef_pkg::ChObjClose,  1'b0, 1,   1'b0, NoFrame},
    '{jdef_pkg::ChArrOpen,   1'b0, 1,   1'b0, NoFrame},
    '{8'hFF,                 1'b0, 1,   1'b0, NoFrame},
    '{jdef_pkg::ChObjOpen,   1'b1, 1,   1'b0, NoFrame},
    '{8'h00,                 1'b0, 1,   1'b0, NoFrame},
    '{jdef_pkg::ChObjClose,  1'b0, 1,   1'b1, '{17'd3, 1'b0, jdef_pkg::STATUS_DONE}},
    '{jdef_pkg::ChArrOpen,   1'b0, 256, 1'b1,
      '{17'd256, 1'b1, jdef_pkg::STATUS_NEST_OVERFLOW}}
  };

  json_document_end_framer_top #(
    .MAX_FRAME_BYTES(FrameLimit),
    .MAX_NESTING(NestLimit)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .data_byte(data_byte),
    .flush(flush),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .frame_length(frame_length),
    .is_array(is_array),
    .status(status)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic void restart_scan();
    in_doc = 1'b0;
    doc_is_array = 1'b0;
    depth = 0;
    in_string = 1'b0;
    escaped = 1'b0;
    seen_bytes = 0;
  endfunction

  function automatic frame_t close_frame(input jdef_pkg::status_t code);
    frame_t res;
    res.len = seen_bytes[16:0];
    res.kind = doc_is_array;
    res.code = code;
    restart_scan();
    return res;
  endfunction

  function automatic bit scan_byte(input logic [7:0] b, input logic f, output frame_t res);
    logic [7:0] opn;
    logic [7:0] cls;
    res = NoFrame;
    if (f) restart_scan();
    seen_bytes++;
    if (!in_doc) begin
      if (b == jdef_pkg::ChObjOpen || b == jdef_pkg::ChArrOpen) begin
        in_doc = 1'b1;
        doc_is_array = (b == jdef_pkg::ChArrOpen);
        depth = 1;
        in_string = 1'b0;
        escaped = 1'b0;
      end
    end else if (escaped) begin
      escaped = 1'b0;
    end else if (b == jdef_pkg::ChBackslash) begin
      escaped = 1'b1;
    end else if (b == jdef_pkg::ChQuote) begin
      in_string = !in_string;
    end else if (!in_string) begin
      opn = doc_is_array ? jdef_pkg::ChArrOpen : jdef_pkg::ChObjOpen;
      cls = doc_is_array ? jdef_pkg::ChArrClose : jdef_pkg::ChObjClose;
      if (b == opn) begin
        if (depth >= NestLimit) begin
          res = close_frame(jdef_pkg::STATUS_NEST_OVERFLOW);
          return 1'b1;
        end
        depth++;
      end else if (b == cls) begin
        depth--;
        if (depth == 0) begin
          res = close_frame(jdef_pkg::STATUS_DONE);
          return 1'b1;
        end
      end
    end
    if (seen_bytes >= FrameLimit) begin
      res = close_frame(jdef_pkg::STATUS_LENGTH_OVERFLOW);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Entered just after a falling edge; returns at the falling edge after the word is taken.
  task automatic send_byte(input logic [7:0] b, input logic f, input int unsigned gap,
                           input bit fixed, input frame_t want);
    frame_t res;
    bit produced;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    flush <= f;
    do @(posedge clk); while (!in_ready);
    produced = scan_byte(b, f, res);
    if (fixed) frames_due.push_back(want);
    else if (produced) frames_due.push_back(res);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (frames_due.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic add_byte(input logic [7:0] b);
    burst_bytes.push_back(b);
    burst_flush.push_back(1'b0);
  endtask

  function automatic logic [7:0] filler_byte();
    return 8'($urandom_range(8'h23, 8'h5A));
  endfunction

  task automatic build_document();
    bit arr;
    bit quoted;
    int unsigned levels;
    int unsigned room;
    logic [7:0] opn;
    logic [7:0] cls;
    logic [7:0] r;
    arr = 1'($urandom_range(0, 1));
    opn = arr ? jdef_pkg::ChArrOpen : jdef_pkg::ChObjOpen;
    cls = arr ? jdef_pkg::ChArrClose : jdef_pkg::ChObjClose;
    quoted = 1'b0;
    levels = 1;
    repeat ($urandom_range(0, 3)) begin
      r = 8'($urandom);
      if (r == jdef_pkg::ChObjOpen || r == jdef_pkg::ChArrOpen) r = 8'h20;
      add_byte(r);
    end
    add_byte(opn);
    room = $urandom_range(2, 40);
    while (levels > 0 && room > 0) begin
      room--;
      case ($urandom_range(0, 9))
        0: begin
          if (!quoted && levels < 12) begin
            add_byte(opn);
            levels++;
          end else begin
            add_byte(filler_byte());
          end
        end
        1, 2: begin
          if (!quoted) begin
            add_byte(cls);
            levels--;
          end else begin
            add_byte(filler_byte());
          end
        end
        3: begin
          add_byte(jdef_pkg::ChQuote);
          quoted = !quoted;
        end
        4: begin
          add_byte(jdef_pkg::ChBackslash);
          add_byte(8'($urandom));
        end
        5: begin
          if (quoted) begin
            r = 8'($urandom);
            if (r == jdef_pkg::ChQuote || r == jdef_pkg::ChBackslash) r = 8'h2C;
            add_byte(r);
          end else if (arr) begin
            add_byte($urandom_range(0, 1) ? jdef_pkg::ChObjOpen : jdef_pkg::ChObjClose);
          end else begin
            add_byte($urandom_range(0, 1) ? jdef_pkg::ChArrOpen : jdef_pkg::ChArrClose);
          end
        end
        default: add_byte(filler_byte());
      endcase
    end
    if (quoted) add_byte(jdef_pkg::ChQuote);
    while (levels > 0) begin
      add_byte(cls);
      levels--;
    end
  endtask

  initial begin
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 1)) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  always @(posedge clk) begin
    frame_t want;
    if (!rst && out_valid && out_ready) begin
      if (frames_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: length %0d array %0d status %0d",
                   frame_length, is_array, status);
      end else begin
        want = frames_due.pop_front();
        if (frame_length !== want.len || is_array !== want.kind || status !== want.code) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected length %0d array %0d status %0d, got %0d %0d %0d",
                     want.len, want.kind, want.code, frame_length, is_array, status);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles == StallLimit) begin
        $display("testbench: FAIL");
        $finish;
      end
    end
  end

  initial begin
    int unsigned sent;
    int unsigned pick;
    int unsigned cut;
    bit flush_pending;
    restart_scan();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (plan[i]) begin
      for (int unsigned k = 0; k < plan[i].reps; k++)
        send_byte(plan[i].value, plan[i].fl, (plan[i].reps > 1) ? 0 : $urandom_range(0, 19),
                  plan[i].fixed && (k == plan[i].reps - 1), plan[i].want);
    end
    drain_results();

    sent = 0;
    flush_pending = 1'b0;
    while (sent < RandomItems) begin
      burst_bytes.delete();
      burst_flush.delete();
      pick = $urandom_range(0, 9);
      if (pick < 8) begin
        build_document();
        if (pick == 7) begin
          cut = $urandom_range(1, burst_bytes.size() - 1);
          repeat (cut) begin
            void'(burst_bytes.pop_back());
            void'(burst_flush.pop_back());
          end
        end
      end else begin
        repeat ($urandom_range(1, 16)) begin
          burst_bytes.push_back(8'($urandom));
          burst_flush.push_back($urandom_range(0, 15) == 0);
        end
      end
      if (flush_pending) burst_flush[0] = 1'b1;
      flush_pending = (pick == 7);
      if ($urandom_range(0, 15) == 0) calm = !calm;
      if ($urandom_range(0, 40) == 0) drain_results();
      foreach (burst_bytes[j])
        send_byte(burst_bytes[j], burst_flush[j], calm ? 0 : $urandom_range(0, 19),
                  1'b0, NoFrame);
      sent += burst_bytes.size();
    end

    drain_results();
    repeat (TailCycles) @(posedge clk);
    if (mismatches == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
